// ===== rtl/fvs_pkg.sv =====
// Shared types, constants and the sine table of the four-voice sine synthesiser and mixer.
// The sine table is worked out at elaboration from a fixed-point Taylor series.
// No dependencies; every other file of the block refers to this package.
package fvs_pkg;

    localparam int NUM_VOICES = 4;
    localparam int V_LEAD = 0;
    localparam int V_BASS = 1;
    localparam int V_KICK = 2;
    localparam int V_SNARE = 3;

    localparam int AMP_W = 15;
    localparam int SHIFT_W = 4;
    localparam int HZ_W = 12;
    localparam int PHASE_W = 32;
    localparam int SAMPLE_W = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int SAMPLE_RATE_DEFAULT = 32000;
    localparam int KICK_HZ = 60;
    localparam int SNARE_HZ = 220;

    localparam logic [NUM_VOICES-1:0][AMP_W-1:0] BASE_AMP_RESET =
        {15'd14000, 15'd18000, 15'd13000, 15'd11000};
    localparam logic [NUM_VOICES-1:0][SHIFT_W-1:0] DECAY_SHIFT_RESET =
        {4'd7, 4'd8, 4'd11, 4'd12};

    localparam logic [31:0] NOISE_SEED = 32'h0000_ACE1;
    localparam logic [16:0] NOISE_OFFSET = 17'd16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEAD_AMP    = 3'd0,
        REG_BASS_AMP    = 3'd1,
        REG_KICK_AMP    = 3'd2,
        REG_SNARE_AMP   = 3'd3,
        REG_LEAD_SHIFT  = 3'd4,
        REG_BASS_SHIFT  = 3'd5,
        REG_KICK_SHIFT  = 3'd6,
        REG_SNARE_SHIFT = 3'd7
    } t_cfg_index;

    // Sine table: entry n is 8000 * sin(2*pi*n/depth), rounded towards zero.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam logic [63:0] ROM_PEAK = 64'd8000;
    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
    localparam int TAYLOR_TERMS = 12;
    localparam logic [TAYLOR_TERMS-1:0][63:0] TAYLOR_DIV = {
        64'd600, 64'd506, 64'd420, 64'd342, 64'd272, 64'd210,
        64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    typedef logic [SINE_TABLE_DEPTH-1:0][SAMPLE_W-1:0] t_sine_rom;

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        logic [63:0] d;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] t;
        logic signed [63:0] sum;
        logic [63:0] mag;
        logic neg;
        d = 64'(SINE_TABLE_DEPTH);
        for (int n = 0; n < SINE_TABLE_DEPTH; n++) begin
            u = 64'(n) << 2;
            neg = 1'b0;
            if (u >= 2 * d) begin
                neg = 1'b1;
                u = u - 2 * d;
            end
            if (u > d) begin
                u = 2 * d - u;
            end
            if (u == 64'd0) begin
                mag = 64'd0;
            end else if (u == d) begin
                mag = ROM_PEAK;
            end else begin
                x = HALF_PI_Q31 * u / SINE_TABLE_DEPTH;
                t = x;
                sum = signed'(x);
                for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                    t = (t * x) >> 31;
                    t = (t * x) >> 31;
                    t = t / TAYLOR_DIV[k-1];
                    if ((k % 2) == 1) begin
                        sum = sum - signed'(t);
                    end else begin
                        sum = sum + signed'(t);
                    end
                end
                if (sum < 0) begin
                    sum = 64'sd0;
                end
                mag = (unsigned'(sum) * ROM_PEAK) >> 31;
            end
            rom[n] = neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    typedef struct packed {
        logic [NUM_VOICES-1:0] trig;
        logic [NUM_VOICES-1:0][PHASE_W-1:0] step;
    } t_trig;

    typedef struct packed {
        logic [NUM_VOICES-1:0][SAMPLE_W-1:0] sample;
        logic [NUM_VOICES-1:0][AMP_W-1:0] amp;
        logic [16:0] noise;
    } t_voice_out;

    typedef struct packed {
        logic [SAMPLE_W-1:0] lead;
        logic [SAMPLE_W-1:0] bass;
        logic [SAMPLE_W-1:0] kick;
        logic [SAMPLE_W+1:0] snare;
    } t_voice_prod;

endpackage

// ===== rtl/fvs_voice_bank.sv =====
// Oscillator bank: phase accumulators, phase steps, decay envelopes and the noise LFSR.
// Reads the sine table with the top phase bits and registers samples and amplitudes.
// Depends on fvs_pkg.
module fvs_voice_bank (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_en,
    input  fvs_pkg::t_trig                                        i_trig,
    input  logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0]    i_base_amp,
    input  logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::SHIFT_W-1:0]  i_decay_shift,
    output fvs_pkg::t_voice_out                                   o_voice
);

    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::PHASE_W-1:0] r_phase;
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::PHASE_W-1:0] r_step;
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0]   r_amp;
    logic [31:0]                                          r_noise;
    fvs_pkg::t_voice_out                                  r_voice;

    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::PHASE_W-1:0] n_phase;
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::PHASE_W-1:0] n_step;
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0]   n_amp;
    logic [31:0]                                          n_noise;
    fvs_pkg::t_voice_out                                  n_voice;
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0]   amp_eff;
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0]   decay;
    logic                                                 feedback;

    always_comb begin
        for (int v = 0; v < fvs_pkg::NUM_VOICES; v++) begin
            amp_eff[v] = i_trig.trig[v] ? i_base_amp[v] : r_amp[v];
            n_step[v] = i_trig.trig[v] ? i_trig.step[v] : r_step[v];
            n_phase[v] = r_phase[v] + n_step[v];
            decay[v] = i_base_amp[v] >> i_decay_shift[v];
            if (decay[v] == '0) begin
                decay[v] = fvs_pkg::AMP_W'(1);
            end
            n_amp[v] = (amp_eff[v] > decay[v]) ? amp_eff[v] - decay[v] : '0;
            n_voice.sample[v] = fvs_pkg::SINE_ROM[
                r_phase[v][fvs_pkg::PHASE_W-1 -: fvs_pkg::SINE_ADDR_W]];
            n_voice.amp[v] = amp_eff[v];
        end
        feedback = r_noise[0] ^ r_noise[1] ^ r_noise[21] ^ r_noise[31];
        n_noise = {feedback, r_noise[31:1]};
        n_voice.noise = {n_noise[15], n_noise[15:0]} - fvs_pkg::NOISE_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= '0;
            r_amp   <= '0;
            r_noise <= fvs_pkg::NOISE_SEED;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_amp   <= n_amp;
            r_noise <= n_noise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_voice <= n_voice;
        end
    end

    assign o_voice = r_voice;

endmodule

// ===== rtl/fvs_scale.sv =====
// Amplitude scaling: each sine sample times its envelope, plus the snare noise term.
// One registered stage of small signed multipliers: one per voice and one for the noise.
// Depends on fvs_pkg.
module fvs_scale (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  fvs_pkg::t_voice_out  i_voice,
    output fvs_pkg::t_voice_prod o_prod
);

    logic signed [31:0] prod [fvs_pkg::NUM_VOICES];
    logic signed [15:0] term [fvs_pkg::NUM_VOICES];
    logic signed [32:0] noise_prod;
    logic signed [16:0] noise_term;
    fvs_pkg::t_voice_prod n_prod;
    fvs_pkg::t_voice_prod r_prod;

    always_comb begin
        for (int v = 0; v < fvs_pkg::NUM_VOICES; v++) begin
            prod[v] = 32'(signed'(i_voice.sample[v]))
                    * 32'(signed'({1'b0, i_voice.amp[v]}));
            term[v] = 16'(prod[v] >>> 15);
        end
        noise_prod = 33'(signed'(i_voice.noise))
                   * 33'(signed'({1'b0, i_voice.amp[fvs_pkg::V_SNARE]}));
        noise_term = 17'(noise_prod >>> 16);
        n_prod.lead = term[fvs_pkg::V_LEAD];
        n_prod.bass = term[fvs_pkg::V_BASS];
        n_prod.kick = term[fvs_pkg::V_KICK];
        n_prod.snare = {{2{term[fvs_pkg::V_SNARE][15]}}, term[fvs_pkg::V_SNARE]}
                     + {noise_term[16], noise_term};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/fvs_mix.sv =====
// Stereo mixer: pans the four voices, saturates each channel to 16 bits and
// holds the result in the output register. Depends on fvs_pkg.
module fvs_mix (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  fvs_pkg::t_voice_prod i_prod,
    output logic signed [15:0]   o_left_sample,
    output logic signed [15:0]   o_right_sample
);

    logic signed [19:0] lead_x;
    logic signed [19:0] bass_x;
    logic signed [19:0] kick_x;
    logic signed [19:0] snare_x;
    logic signed [19:0] left_sum;
    logic signed [19:0] right_sum;
    logic signed [15:0] n_left;
    logic signed [15:0] n_right;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;

    always_comb begin
        lead_x  = {{4{i_prod.lead[15]}}, i_prod.lead};
        bass_x  = {{4{i_prod.bass[15]}}, i_prod.bass};
        kick_x  = {{4{i_prod.kick[15]}}, i_prod.kick};
        snare_x = {{2{i_prod.snare[17]}}, i_prod.snare};
        left_sum  = bass_x + kick_x + snare_x + (lead_x >>> 1);
        right_sum = bass_x + kick_x + (snare_x >>> 1) + lead_x;
        priority if (left_sum > 20'sd32767) begin
            n_left = 16'sh7FFF;
        end else if (left_sum < -20'sd32768) begin
            n_left = 16'sh8000;
        end else begin
            n_left = left_sum[15:0];
        end
        priority if (right_sum > 20'sd32767) begin
            n_right = 16'sh7FFF;
        end else if (right_sum < -20'sd32768) begin
            n_right = 16'sh8000;
        end else begin
            n_right = right_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left_sample  = r_left;
    assign o_right_sample = r_right;

endmodule

// ===== rtl/four_voice_sine_synth_mixer_core.sv =====
// Top level of the four-voice sine synthesiser and stereo mixer: handshakes,
// configuration registers, trigger decode and the four-stage pipeline.
// Depends on fvs_pkg, fvs_voice_bank, fvs_scale and fvs_mix.
//
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_ready  i_lead_hz, i_bass_hz, i_kick_trigger,
//                                               i_snare_trigger
// output    out        o_out_valid / i_out_ready o_left_sample, o_right_sample
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample transaction is accepted every cycle while o_in_ready is high; its result is valid
// after the input register, then the oscillator bank, multipliers and mixer output register.
// Reset is synchronous and active low; it clears all voice state, reloads the
// register defaults and seeds the noise generator. No clearing pass is needed.
// Each stage holds while the stage after it is full, so a stalled output fills
// the pipeline before o_in_ready drops. Configuration writes are never stalled.
module four_voice_sine_synth_mixer_core #(
    parameter int SAMPLE_RATE = fvs_pkg::SAMPLE_RATE_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fvs_pkg::HZ_W-1:0]          i_lead_hz,
    input  logic [fvs_pkg::HZ_W-1:0]          i_bass_hz,
    input  logic                              i_kick_trigger,
    input  logic                              i_snare_trigger,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [15:0]                o_left_sample,
    output logic signed [15:0]                o_right_sample,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fvs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [fvs_pkg::AMP_W-1:0]         i_cfg_data
);

    // Phase step = floor(hz * 2^32 / SAMPLE_RATE) through a rounded-up reciprocal.
    localparam int STEP_SHIFT = 29;
    localparam logic [63:0] STEP_MULT =
        ((64'd1 << (32 + STEP_SHIFT)) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam int PROD_W = fvs_pkg::HZ_W + 64;
    localparam logic [63:0] KICK_STEP_WIDE =
        (64'(fvs_pkg::KICK_HZ) << 32) / 64'(SAMPLE_RATE);
    localparam logic [63:0] SNARE_STEP_WIDE =
        (64'(fvs_pkg::SNARE_HZ) << 32) / 64'(SAMPLE_RATE);
    localparam logic [fvs_pkg::PHASE_W-1:0] KICK_STEP = KICK_STEP_WIDE[31:0];
    localparam logic [fvs_pkg::PHASE_W-1:0] SNARE_STEP = SNARE_STEP_WIDE[31:0];

    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0]   r_base_amp;
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::SHIFT_W-1:0] r_decay_shift;

    logic r_s0_valid;
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    fvs_pkg::t_trig r_s0;
    fvs_pkg::t_trig n_s0;

    logic [PROD_W-1:0] lead_prod;
    logic [PROD_W-1:0] bass_prod;
    logic rdy_out;
    logic rdy2;
    logic rdy1;
    logic rdy0;
    logic adv0;
    logic adv1;
    logic adv2;
    logic in_acc;

    fvs_pkg::t_voice_out  voice;
    fvs_pkg::t_voice_prod prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_amp    <= fvs_pkg::BASE_AMP_RESET;
            r_decay_shift <= fvs_pkg::DECAY_SHIFT_RESET;
        end else if (i_cfg_valid) begin
            unique case (fvs_pkg::t_cfg_index'(i_cfg_index))
                fvs_pkg::REG_LEAD_AMP: begin
                    r_base_amp[fvs_pkg::V_LEAD] <= i_cfg_data;
                end
                fvs_pkg::REG_BASS_AMP: begin
                    r_base_amp[fvs_pkg::V_BASS] <= i_cfg_data;
                end
                fvs_pkg::REG_KICK_AMP: begin
                    r_base_amp[fvs_pkg::V_KICK] <= i_cfg_data;
                end
                fvs_pkg::REG_SNARE_AMP: begin
                    r_base_amp[fvs_pkg::V_SNARE] <= i_cfg_data;
                end
                fvs_pkg::REG_LEAD_SHIFT: begin
                    r_decay_shift[fvs_pkg::V_LEAD] <= i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                end
                fvs_pkg::REG_BASS_SHIFT: begin
                    r_decay_shift[fvs_pkg::V_BASS] <= i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                end
                fvs_pkg::REG_KICK_SHIFT: begin
                    r_decay_shift[fvs_pkg::V_KICK] <= i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                end
                fvs_pkg::REG_SNARE_SHIFT: begin
                    r_decay_shift[fvs_pkg::V_SNARE] <= i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign lead_prod = PROD_W'(i_lead_hz) * PROD_W'(STEP_MULT);
    assign bass_prod = PROD_W'(i_bass_hz) * PROD_W'(STEP_MULT);

    always_comb begin
        n_s0.trig[fvs_pkg::V_LEAD]  = (i_lead_hz != '0);
        n_s0.trig[fvs_pkg::V_BASS]  = (i_bass_hz != '0);
        n_s0.trig[fvs_pkg::V_KICK]  = i_kick_trigger;
        n_s0.trig[fvs_pkg::V_SNARE] = i_snare_trigger;
        n_s0.step[fvs_pkg::V_LEAD]  = lead_prod[STEP_SHIFT +: fvs_pkg::PHASE_W];
        n_s0.step[fvs_pkg::V_BASS]  = bass_prod[STEP_SHIFT +: fvs_pkg::PHASE_W];
        n_s0.step[fvs_pkg::V_KICK]  = KICK_STEP;
        n_s0.step[fvs_pkg::V_SNARE] = SNARE_STEP;
    end

    assign rdy_out = !r_out_valid || i_out_ready;
    assign rdy2    = !r_s2_valid || rdy_out;
    assign rdy1    = !r_s1_valid || rdy2;
    assign rdy0    = !r_s0_valid || rdy1;
    assign adv2    = r_s2_valid && rdy_out;
    assign adv1    = r_s1_valid && rdy2;
    assign adv0    = r_s0_valid && rdy1;
    assign in_acc  = i_in_valid && rdy0;
    assign o_in_ready  = rdy0;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_valid  <= in_acc || (r_s0_valid && !adv0);
            r_s1_valid  <= adv0 || (r_s1_valid && !adv1);
            r_s2_valid  <= adv1 || (r_s2_valid && !adv2);
            r_out_valid <= adv2 || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0 <= n_s0;
        end
    end

    fvs_voice_bank u_voice_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv0),
        .i_trig        (r_s0),
        .i_base_amp    (r_base_amp),
        .i_decay_shift (r_decay_shift),
        .o_voice       (voice)
    );

    fvs_scale u_scale (
        .i_clk   (i_clk),
        .i_en    (adv1),
        .i_voice (voice),
        .o_prod  (prod)
    );

    fvs_mix u_mix (
        .i_clk          (i_clk),
        .i_en           (adv2),
        .i_prod         (prod),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample)
    );

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s0_valid && r_s1_valid && r_s2_valid && r_out_valid))
        else $error("input stalled while the pipeline has a free stage");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !rdy2) |=> r_s1_valid)
        else $error("oscillator stage transaction lost while stalled");

    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid))
        else $error("output became valid without a transaction in the multiplier stage");

endmodule

// ===== dv/four_voice_mix_checker.sv =====
// Checker of the four-voice sine synthesiser and mixer: it watches the sample, result and
// register channels, predicts every stereo sample and compares it with the block's output.
// Depends on fvs_pkg for widths, voice numbers, register indexes and reset settings.
module four_voice_mix_checker #(
    parameter int SAMPLE_RATE = fvs_pkg::SAMPLE_RATE_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [fvs_pkg::HZ_W-1:0]        i_lead_hz,
    input  logic [fvs_pkg::HZ_W-1:0]        i_bass_hz,
    input  logic                            i_kick_trigger,
    input  logic                            i_snare_trigger,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [15:0]              i_left_sample,
    input  logic signed [15:0]              i_right_sample,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [fvs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fvs_pkg::AMP_W-1:0]       i_cfg_data,
    output int                              o_pending,
    output int                              o_mismatches
);

    localparam logic [63:0] WAVE_PEAK = 64'd8000;
    localparam logic [63:0] QUARTER_TURN_Q31 = 64'd3373259426;
    localparam int SERIES_TERMS = 12;
    localparam logic [31:0] NOISE_START = 32'h0000_ACE1;
    localparam longint NOISE_BIAS = 16384;

    typedef struct packed {
        logic signed [fvs_pkg::SAMPLE_W-1:0] left;
        logic signed [fvs_pkg::SAMPLE_W-1:0] right;
    } t_stereo;

    logic signed [fvs_pkg::SAMPLE_W-1:0] wave_tab [fvs_pkg::SINE_TABLE_DEPTH];
    logic [fvs_pkg::PHASE_W-1:0]         osc_phase [fvs_pkg::NUM_VOICES];
    logic [fvs_pkg::PHASE_W-1:0]         osc_incr [fvs_pkg::NUM_VOICES];
    logic [fvs_pkg::AMP_W-1:0]           tone_amp [fvs_pkg::NUM_VOICES];
    logic [fvs_pkg::AMP_W-1:0]           peak_amp [fvs_pkg::NUM_VOICES];
    logic [fvs_pkg::SHIFT_W-1:0]         fall_shift [fvs_pkg::NUM_VOICES];
    logic [31:0]                         noise_lfsr;
    t_stereo                             expected_mix [$];
    t_stereo                             oldest_mix;
    int                                  fault_count = 0;

    // Quarter-wave reduction and a Taylor series in unsigned Q31, truncated towards zero.
    initial begin
        logic [63:0] depth;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] mag;
        longint      sum;
        logic        negative;
        depth = 64'(fvs_pkg::SINE_TABLE_DEPTH);
        for (int n = 0; n < fvs_pkg::SINE_TABLE_DEPTH; n++) begin
            u = 64'(n) * 64'd4;
            negative = 1'b0;
            if (u >= 2 * depth) begin
                negative = 1'b1;
                u = u - 2 * depth;
            end
            if (u > depth) begin
                u = 2 * depth - u;
            end
            if (u == 64'd0) begin
                mag = 64'd0;
            end else if (u == depth) begin
                mag = WAVE_PEAK;
            end else begin
                x = QUARTER_TURN_Q31 * u / depth;
                t = x;
                sum = longint'(x);
                for (int k = 1; k <= SERIES_TERMS; k++) begin
                    t = (t * x) >> 31;
                    t = (t * x) >> 31;
                    t = t / (64'(2 * k) * 64'(2 * k + 1));
                    if ((k % 2) == 1) begin
                        sum = sum - longint'(t);
                    end else begin
                        sum = sum + longint'(t);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                mag = (unsigned'(sum) * WAVE_PEAK) >> 31;
            end
            wave_tab[n] = negative ? -fvs_pkg::SAMPLE_W'(mag) : fvs_pkg::SAMPLE_W'(mag);
        end
    end

    function automatic logic signed [fvs_pkg::SAMPLE_W-1:0] clip_to_sample(
            input longint acc);
        if (acc > 32767) begin
            return 16'sh7FFF;
        end else if (acc < -32768) begin
            return 16'sh8000;
        end
        return acc[fvs_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic t_stereo advance_synth(input logic [fvs_pkg::HZ_W-1:0] lead_hz,
                                              input logic [fvs_pkg::HZ_W-1:0] bass_hz,
                                              input logic kick, input logic snare);
        logic [fvs_pkg::HZ_W-1:0]        hz [fvs_pkg::NUM_VOICES];
        logic                            fire [fvs_pkg::NUM_VOICES];
        longint                          voice_out [fvs_pkg::NUM_VOICES];
        longint                          wave;
        longint                          level;
        longint                          noise_val;
        longint                          centre;
        logic [fvs_pkg::SINE_ADDR_W-1:0] idx;
        logic [fvs_pkg::AMP_W-1:0]       drop;
        logic                            fb;
        t_stereo                         mix;
        hz[fvs_pkg::V_LEAD] = lead_hz;
        hz[fvs_pkg::V_BASS] = bass_hz;
        hz[fvs_pkg::V_KICK] = fvs_pkg::HZ_W'(fvs_pkg::KICK_HZ);
        hz[fvs_pkg::V_SNARE] = fvs_pkg::HZ_W'(fvs_pkg::SNARE_HZ);
        fire[fvs_pkg::V_LEAD] = (lead_hz != '0);
        fire[fvs_pkg::V_BASS] = (bass_hz != '0);
        fire[fvs_pkg::V_KICK] = kick;
        fire[fvs_pkg::V_SNARE] = snare;
        for (int v = 0; v < fvs_pkg::NUM_VOICES; v++) begin
            if (fire[v]) begin
                osc_incr[v] = fvs_pkg::PHASE_W'((64'(hz[v]) << 32) / 64'(SAMPLE_RATE));
                tone_amp[v] = peak_amp[v];
            end
        end
        for (int v = 0; v < fvs_pkg::NUM_VOICES; v++) begin
            idx = fvs_pkg::SINE_ADDR_W'(
                (64'(osc_phase[v]) * 64'(fvs_pkg::SINE_TABLE_DEPTH)) >> 32);
            wave = longint'(wave_tab[idx]);
            level = longint'(tone_amp[v]);
            osc_phase[v] = osc_phase[v] + osc_incr[v];
            voice_out[v] = (wave * level) >>> 15;
        end
        fb = noise_lfsr[0] ^ noise_lfsr[1] ^ noise_lfsr[21] ^ noise_lfsr[31];
        noise_lfsr = {fb, noise_lfsr[31:1]};
        noise_val = longint'($signed(noise_lfsr[15:0]));
        noise_val = noise_val - NOISE_BIAS;
        level = longint'(tone_amp[fvs_pkg::V_SNARE]);
        voice_out[fvs_pkg::V_SNARE] = voice_out[fvs_pkg::V_SNARE]
                                    + ((noise_val * level) >>> 16);
        for (int v = 0; v < fvs_pkg::NUM_VOICES; v++) begin
            if (tone_amp[v] != '0) begin
                drop = peak_amp[v] >> fall_shift[v];
                if (drop == '0) begin
                    drop = fvs_pkg::AMP_W'(1);
                end
                tone_amp[v] = (tone_amp[v] > drop) ? tone_amp[v] - drop : '0;
            end
        end
        centre = voice_out[fvs_pkg::V_BASS] + voice_out[fvs_pkg::V_KICK];
        mix.left = clip_to_sample(centre + voice_out[fvs_pkg::V_SNARE]
                                  + (voice_out[fvs_pkg::V_LEAD] >>> 1));
        mix.right = clip_to_sample(centre + (voice_out[fvs_pkg::V_SNARE] >>> 1)
                                   + voice_out[fvs_pkg::V_LEAD]);
        return mix;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < fvs_pkg::NUM_VOICES; v++) begin
                osc_phase[v] = '0;
                osc_incr[v] = '0;
                tone_amp[v] = '0;
                peak_amp[v] = fvs_pkg::BASE_AMP_RESET[v];
                fall_shift[v] = fvs_pkg::DECAY_SHIFT_RESET[v];
            end
            noise_lfsr = NOISE_START;
            expected_mix.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_mix.size() == 0) begin
                    $error("unexpected output transaction: left_sample %0d, right_sample %0d",
                           i_left_sample, i_right_sample);
                    fault_count++;
                end else begin
                    oldest_mix = expected_mix.pop_front();
                    if (i_left_sample !== oldest_mix.left) begin
                        $error("left_sample: expected %0d, actual %0d",
                               oldest_mix.left, i_left_sample);
                        fault_count++;
                    end
                    if (i_right_sample !== oldest_mix.right) begin
                        $error("right_sample: expected %0d, actual %0d",
                               oldest_mix.right, i_right_sample);
                        fault_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fvs_pkg::REG_LEAD_AMP:    peak_amp[fvs_pkg::V_LEAD] = i_cfg_data;
                    fvs_pkg::REG_BASS_AMP:    peak_amp[fvs_pkg::V_BASS] = i_cfg_data;
                    fvs_pkg::REG_KICK_AMP:    peak_amp[fvs_pkg::V_KICK] = i_cfg_data;
                    fvs_pkg::REG_SNARE_AMP:   peak_amp[fvs_pkg::V_SNARE] = i_cfg_data;
                    fvs_pkg::REG_LEAD_SHIFT:
                        fall_shift[fvs_pkg::V_LEAD] = i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                    fvs_pkg::REG_BASS_SHIFT:
                        fall_shift[fvs_pkg::V_BASS] = i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                    fvs_pkg::REG_KICK_SHIFT:
                        fall_shift[fvs_pkg::V_KICK] = i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                    fvs_pkg::REG_SNARE_SHIFT:
                        fall_shift[fvs_pkg::V_SNARE] = i_cfg_data[fvs_pkg::SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_mix.push_back(advance_synth(i_lead_hz, i_bass_hz,
                                                     i_kick_trigger, i_snare_trigger));
            end
        end
        o_pending <= expected_mix.size();
        o_mismatches <= fault_count;
    end

endmodule

// ===== dv/tb_four_voice_sine_synth_mixer_core.sv =====
// Testbench top of the four-voice sine synthesiser and mixer: clock, reset, sample and
// register stimulus with bursty sending and output stalls, and the final verdict.
// Depends on fvs_pkg, four_voice_sine_synth_mixer_core and four_voice_mix_checker.
module tb_four_voice_sine_synth_mixer_core;

    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_PHASES = 6;
    localparam int TICKS_PER_PHASE = 92;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_BLOCKED,
        RX_ALTERNATE
    } t_rx_mode;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [fvs_pkg::HZ_W-1:0]     lead_hz = '0;
    logic [fvs_pkg::HZ_W-1:0]     bass_hz = '0;
    logic                         kick_trig = 1'b0;
    logic                         snare_trig = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [15:0]           left_sample;
    logic signed [15:0]           right_sample;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    fvs_pkg::t_cfg_index          cfg_index = fvs_pkg::REG_LEAD_AMP;
    logic [fvs_pkg::AMP_W-1:0]    cfg_data = '0;

    int       pending;
    int       mismatches;
    int       ticks_sent = 0;
    int       reg_writes = 0;
    int       settings_used = 1;
    int       burst_left = 0;
    int       idle_cycles = 0;
    int       rx_left = 0;
    t_rx_mode rx_mode = RX_OPEN;

    always #4 clk = ~clk;

    four_voice_sine_synth_mixer_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_lead_hz      (lead_hz),
        .i_bass_hz      (bass_hz),
        .i_kick_trigger (kick_trig),
        .i_snare_trigger(snare_trig),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_left_sample  (left_sample),
        .o_right_sample (right_sample),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    four_voice_mix_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_lead_hz      (lead_hz),
        .i_bass_hz      (bass_hz),
        .i_kick_trigger (kick_trig),
        .i_snare_trigger(snare_trig),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_left_sample  (left_sample),
        .i_right_sample (right_sample),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_mismatches   (mismatches)
    );

    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 12) : $urandom_range(4, 40);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN:    out_ready <= 1'b1;
            RX_RANDOM:  out_ready <= ($urandom_range(0, 2) != 0);
            RX_BLOCKED: out_ready <= 1'b0;
            default:    out_ready <= rx_left[0];
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction on any channel for %0d cycles.", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tick(input logic [fvs_pkg::HZ_W-1:0] lead,
                             input logic [fvs_pkg::HZ_W-1:0] bass,
                             input logic kick, input logic snare);
        int gap_len;
        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 32);
            for (int g = 0; g < gap_len; g++) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        lead_hz <= lead;
        bass_hz <= bass;
        kick_trig <= kick;
        snare_trig <= snare;
        in_valid <= 1'b1;
        burst_left--;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    // Most ticks behave like a sequencer: sparse note triggers with long decays between them.
    task automatic send_random_tick();
        logic [fvs_pkg::HZ_W-1:0] lead;
        logic [fvs_pkg::HZ_W-1:0] bass;
        logic                     kick;
        logic                     snare;
        if ($urandom_range(0, 9) == 0) begin
            lead = fvs_pkg::HZ_W'($urandom_range(0, 4095));
            bass = fvs_pkg::HZ_W'($urandom_range(0, 4095));
            kick = 1'($urandom_range(0, 1));
            snare = 1'($urandom_range(0, 1));
        end else begin
            lead = '0;
            bass = '0;
            if ($urandom_range(0, 7) == 0) begin
                lead = ($urandom_range(0, 3) == 0) ? fvs_pkg::HZ_W'($urandom_range(1, 4095))
                                                   : fvs_pkg::HZ_W'($urandom_range(110, 1760));
            end
            if ($urandom_range(0, 9) == 0) begin
                bass = ($urandom_range(0, 3) == 0) ? fvs_pkg::HZ_W'($urandom_range(1, 4095))
                                                   : fvs_pkg::HZ_W'($urandom_range(30, 440));
            end
            kick = ($urandom_range(0, 11) == 0);
            snare = ($urandom_range(0, 13) == 0);
        end
        send_tick(lead, bass, kick, snare);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input fvs_pkg::t_cfg_index idx,
                             input logic [fvs_pkg::AMP_W-1:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic apply_settings(
            input logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0] amps,
            input logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0] shift_words);
        drain();
        write_reg(fvs_pkg::REG_LEAD_AMP, amps[fvs_pkg::V_LEAD]);
        write_reg(fvs_pkg::REG_BASS_AMP, amps[fvs_pkg::V_BASS]);
        write_reg(fvs_pkg::REG_KICK_AMP, amps[fvs_pkg::V_KICK]);
        write_reg(fvs_pkg::REG_SNARE_AMP, amps[fvs_pkg::V_SNARE]);
        write_reg(fvs_pkg::REG_LEAD_SHIFT, shift_words[fvs_pkg::V_LEAD]);
        write_reg(fvs_pkg::REG_BASS_SHIFT, shift_words[fvs_pkg::V_BASS]);
        write_reg(fvs_pkg::REG_KICK_SHIFT, shift_words[fvs_pkg::V_KICK]);
        write_reg(fvs_pkg::REG_SNARE_SHIFT, shift_words[fvs_pkg::V_SNARE]);
        settings_used++;
    endtask

    initial begin
        logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0] amps;
        logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::AMP_W-1:0] shift_words;
        int                                                 pick;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: silence, simultaneous triggers, frequency extremes and drums alone.
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);
        send_tick(12'd4095, 12'd4095, 1'b1, 1'b1);
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);
        send_tick(12'd1, 12'd1, 1'b0, 1'b0);
        send_tick(12'hAAA, 12'h555, 1'b0, 1'b0);
        send_tick(12'h555, 12'hAAA, 1'b0, 1'b0);
        send_tick(12'd0, 12'd0, 1'b1, 1'b0);
        send_tick(12'd0, 12'd0, 1'b0, 1'b1);
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);

        // Full amplitude with the steepest decay: each note lasts a single sample.
        apply_settings({fvs_pkg::NUM_VOICES{15'h7FFF}}, {fvs_pkg::NUM_VOICES{15'h0000}});
        send_tick(12'd1000, 12'd500, 1'b1, 1'b1);
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);
        send_tick(12'd2000, 12'd250, 1'b1, 1'b1);
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);

        // Full amplitude with the slowest decay, so that both channels saturate.
        apply_settings({fvs_pkg::NUM_VOICES{15'h7FFF}}, {fvs_pkg::NUM_VOICES{15'h7FFF}});
        send_tick(12'd4000, 12'd3000, 1'b1, 1'b1);
        repeat (5) send_tick(12'd0, 12'd0, 1'b0, 1'b0);

        // Zero base amplitude: triggers are silent, and the decay step falls back to one.
        apply_settings({fvs_pkg::NUM_VOICES{15'h0000}}, {fvs_pkg::NUM_VOICES{15'h7FF0}});
        send_tick(12'd800, 12'd100, 1'b1, 1'b1);
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);
        send_tick(12'd0, 12'd0, 1'b0, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int v = 0; v < fvs_pkg::NUM_VOICES; v++) begin
                if (p == 0) begin
                    amps[v] = fvs_pkg::BASE_AMP_RESET[v];
                    shift_words[v] = fvs_pkg::AMP_W'(fvs_pkg::DECAY_SHIFT_RESET[v]);
                end else begin
                    pick = $urandom_range(0, 5);
                    amps[v] = (pick == 0) ? 15'h0000 : (pick == 1) ? 15'h7FFF
                                                     : fvs_pkg::AMP_W'($urandom_range(0, 32767));
                    pick = $urandom_range(0, 5);
                    shift_words[v] = fvs_pkg::AMP_W'($urandom_range(0, 32767));
                    if (pick == 0) begin
                        shift_words[v][fvs_pkg::SHIFT_W-1:0] = '0;
                    end else if (pick == 1) begin
                        shift_words[v][fvs_pkg::SHIFT_W-1:0] = '1;
                    end
                end
            end
            apply_settings(amps, shift_words);
            for (int i = 0; i < TICKS_PER_PHASE; i++) begin
                // Halfway through, the sender holds off until the pipeline has emptied.
                if (i == TICKS_PER_PHASE / 2) begin
                    drain();
                end
                send_random_tick();
            end
        end

        drain();
        $display("Sent %0d sample transactions and %0d register writes over %0d settings,",
                 ticks_sent, reg_writes, settings_used);
        $display("with bursty sending and output stalls; %0d mismatches found.", mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fvs_pkg.sv
rtl/fvs_voice_bank.sv
rtl/fvs_scale.sv
rtl/fvs_mix.sv
rtl/four_voice_sine_synth_mixer_core.sv
dv/four_voice_mix_checker.sv
dv/tb_four_voice_sine_synth_mixer_core.sv
